### rtl/core/pfdc_pkg.sv
`timescale 1ns / 1ps
// Package for the palette fade/decay/clamp unit: the entry record, the band codes,
// and the offset decay and channel clamp functions. It depends on nothing.
package pfdc_pkg;

    localparam int PASS_LENGTH = 63;

    // Decay band, taken from the top two bits of the position
    localparam logic [1:0] BAND_NONE  = 2'd0;  // positions 0..15
    localparam logic [1:0] BAND_4_5   = 2'd1;  // positions 16..31
    localparam logic [1:0] BAND_4_3   = 2'd2;  // positions 32..47
    localparam logic [1:0] BAND_2_3   = 2'd3;  // positions 48..63

    typedef logic signed [5:0] t_offset;

    // One classified entry, passed from the front end to the back end
    typedef struct packed {
        logic [14:0] color;
        t_offset     red_off;
        t_offset     green_off;
        t_offset     blue_off;
        logic [5:0]  position;
        logic        last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // d - (d/p + d/q), truncating towards zero. Divide by 3 and by 5 through
    // reciprocal multiplies that are exact for magnitudes up to 32.
    function automatic t_offset decay(input t_offset d, input logic [1:0] band);
        logic [6:0]  dx;
        logic [6:0]  mag;
        logic [12:0] p3;
        logic [8:0]  p5;
        logic [6:0]  q2;
        logic [6:0]  q3;
        logic [6:0]  q4;
        logic [6:0]  q5;
        logic [6:0]  sum;
        logic [6:0]  res;
        dx  = {d[5], d};
        mag = dx[6] ? 7'(-dx) : dx;
        p3  = 13'(mag) * 13'd43;
        p5  = 9'(mag) * 9'd13;
        q2  = mag >> 1;
        q4  = mag >> 2;
        q3  = {1'b0, p3[12:7]};
        q5  = {4'b0, p5[8:6]};
        case (band)
            BAND_NONE: sum = 7'd0;
            BAND_4_5:  sum = q4 + q5;
            BAND_4_3:  sum = q4 + q3;
            BAND_2_3:  sum = q2 + q3;
            default:   sum = 7'd0;
        endcase
        res = dx[6] ? (dx + sum) : (dx - sum);
        return t_offset'(res[5:0]);
    endfunction

    // Add a signed offset to a 5-bit channel and clamp to 0..31
    function automatic logic [4:0] clamp_chan(input logic [4:0] ch, input t_offset off);
        logic [7:0] v;
        v = {3'b0, ch} + {{2{off[5]}}, off};
        if (v[7]) begin
            return 5'd0;
        end else if (v[6:5] != 2'b00) begin
            return 5'd31;
        end else begin
            return v[4:0];
        end
    endfunction

endpackage

### rtl/core/pfdc_front.sv
`timescale 1ns / 1ps
// Front end: accepts entries, tracks position and decaying offsets, builds entry records.
// Depends on pfdc_pkg.
module pfdc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [15:0]        i_color_in,
    input  logic               i_first,
    input  pfdc_pkg::t_offset  i_red_start,
    input  pfdc_pkg::t_offset  i_green_start,
    input  pfdc_pkg::t_offset  i_blue_start,
    output pfdc_pkg::t_entry   o_entry
);

    logic [5:0]        r_count;
    pfdc_pkg::t_offset r_red_off;
    pfdc_pkg::t_offset r_green_off;
    pfdc_pkg::t_offset r_blue_off;

    logic [5:0]        n_count;
    pfdc_pkg::t_offset n_red_off;
    pfdc_pkg::t_offset n_green_off;
    pfdc_pkg::t_offset n_blue_off;
    logic [5:0]        pos;

    always_comb begin
        // first restarts the pass with fresh offsets
        pos         = i_first ? 6'd0 : r_count;
        n_red_off   = pfdc_pkg::decay(i_first ? i_red_start   : r_red_off,   pos[5:4]);
        n_green_off = pfdc_pkg::decay(i_first ? i_green_start : r_green_off, pos[5:4]);
        n_blue_off  = pfdc_pkg::decay(i_first ? i_blue_start  : r_blue_off,  pos[5:4]);
        n_count     = pos + 6'd1;
    end

    always_comb begin
        o_entry.color     = i_color_in[14:0];
        o_entry.red_off   = n_red_off;
        o_entry.green_off = n_green_off;
        o_entry.blue_off  = n_blue_off;
        o_entry.position  = pos;
        o_entry.last      = (pos == 6'(pfdc_pkg::PASS_LENGTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 6'd0;
            r_red_off   <= '0;
            r_green_off <= '0;
            r_blue_off  <= '0;
        end else if (i_accept) begin
            r_count     <= n_count;
            r_red_off   <= n_red_off;
            r_green_off <= n_green_off;
            r_blue_off  <= n_blue_off;
        end
    end

endmodule

### rtl/core/pfdc_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of entry records between front and back end.
// Depends on pfdc_pkg.
module pfdc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pfdc_pkg::t_entry      i_entry,
    input  logic                  i_pop,
    output pfdc_pkg::t_entry      o_entry,
    output pfdc_pkg::t_q_status   o_status
);

    pfdc_pkg::t_entry r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign o_entry        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/pfdc_back.sv
`timescale 1ns / 1ps
// Back end: applies offsets, clamps and repacks the colour into the result register.
// Depends on pfdc_pkg.
module pfdc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pfdc_pkg::t_entry     i_entry,
    input  pfdc_pkg::t_q_status  i_q_status,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic [14:0]          o_color_out,
    output logic [5:0]           o_position,
    output logic                 o_last
);

    logic        r_valid;
    logic [14:0] r_color;
    logic [5:0]  r_position;
    logic        r_last;
    logic [14:0] n_color;

    // take a new record when the result register is free or being drained
    assign o_q_pop = !i_q_status.empty && (!r_valid || i_pop);

    always_comb begin
        n_color[4:0]   = pfdc_pkg::clamp_chan(i_entry.color[4:0],   i_entry.red_off);
        n_color[9:5]   = pfdc_pkg::clamp_chan(i_entry.color[9:5],   i_entry.green_off);
        n_color[14:10] = pfdc_pkg::clamp_chan(i_entry.color[14:10], i_entry.blue_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_color    <= n_color;
            r_position <= i_entry.position;
            r_last     <= i_entry.last;
        end
    end

    assign o_valid     = r_valid;
    assign o_color_out = r_color;
    assign o_position  = r_position;
    assign o_last      = r_last;

endmodule

### rtl/core/palette_fade_decay_clamp_unit.sv
`timescale 1ns / 1ps
// Top level of the palette fade/decay/clamp unit: front end, two-entry queue, back end.
// Depends on pfdc_pkg, pfdc_front, pfdc_queue and pfdc_back.
//
// Streams RGB555 palette entries through a per-channel signed offset that decays
// with position, clamping each channel to 0..31. Push an entry with i_first high to
// start a pass: that loads the three start offsets and sets the position to zero;
// later entries take the following positions, wrapping after 63. Offsets decay
// before each entry by truncating divisions set by the position band (none for
// 0..15, d/4+d/5 for 16..31, d/4+d/3 for 32..47, d/2+d/3 for 48..63), and o_last
// marks position 62. Both sides look like a queue: push while o_full is low, pop
// while o_empty is low. One entry is taken every cycle while o_full is low; a
// result passes from the queue into the result register before it shows on the
// output ports, and can be popped once o_empty is low. The front end holds the
// offset recurrence, so the combinational decay of the offsets sets that rate;
// the two-entry queue lets the front keep taking up to two entries while the
// result side stalls.
module palette_fade_decay_clamp_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_color_in,
    input  logic        i_first,
    input  logic [5:0]  i_red_start,
    input  logic [5:0]  i_green_start,
    input  logic [5:0]  i_blue_start,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [14:0] o_color_out,
    output logic [5:0]  o_position,
    output logic        o_last
);

    pfdc_pkg::t_entry    front_entry;
    pfdc_pkg::t_entry    q_entry;
    pfdc_pkg::t_q_status q_status;
    logic                accept;
    logic                q_pop;
    logic                back_valid;

    // accept a beat whenever the queue has room
    assign accept = i_push && !q_status.full;
    assign o_full = q_status.full;

    pfdc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_color_in    (i_color_in),
        .i_first       (i_first),
        .i_red_start   (pfdc_pkg::t_offset'(i_red_start)),
        .i_green_start (pfdc_pkg::t_offset'(i_green_start)),
        .i_blue_start  (pfdc_pkg::t_offset'(i_blue_start)),
        .o_entry       (front_entry)
    );

    // hold classified entries while the result side stalls
    pfdc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_entry  (front_entry),
        .i_pop    (q_pop),
        .o_entry  (q_entry),
        .o_status (q_status)
    );

    pfdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (q_entry),
        .i_q_status  (q_status),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_valid     (back_valid),
        .o_color_out (o_color_out),
        .o_position  (o_position),
        .o_last      (o_last)
    );

    assign o_empty = !back_valid;

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result shown after reset");

    // the queue can only fill while a result waits unpopped
    a_full_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !o_empty)
        else $error("queue full with empty result register");

    // last flag travels with the final position of the pass
    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_last) |-> (o_position == 6'(pfdc_pkg::PASS_LENGTH - 1)))
        else $error("last flag on wrong position");

endmodule

### verif/tb_palette_fade_decay_clamp_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for palette_fade_decay_clamp_unit: a directed table followed by
// random palette passes, each result checked against an in-bench fade predictor.
// Depends on pfdc_pkg and the RTL of palette_fade_decay_clamp_unit.
module tb_palette_fade_decay_clamp_unit;

    localparam int CLK_HALF_NS    = 2;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int RX_HOLD_CYCLES = 64;        // long receiver hold, fills the block
    localparam int END_SETTLE     = 8;         // cycles after the last result to catch strays
    localparam int TIMEOUT_NS     = 3_000_000; // generous: far beyond the slowest correct run
    localparam int STIM_ROWS      = 20;

    // One result beat as the block presents it
    typedef struct packed {
        logic [14:0] color;
        logic [5:0]  position;
        logic        last;
    } t_fade_beat;

    // One row of the directed table; exp_* only meaningful when typed is set
    typedef struct packed {
        logic [15:0] color;
        logic        first;
        logic [5:0]  red_st;
        logic [5:0]  green_st;
        logic [5:0]  blue_st;
        logic        typed;
        t_fade_beat  exp;
    } t_stim_row;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [15:0] i_color_in = '0;
    logic        i_first = 1'b0;
    logic [5:0]  i_red_start = '0;
    logic [5:0]  i_green_start = '0;
    logic [5:0]  i_blue_start = '0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic [14:0] o_color_out;
    logic [5:0]  o_position;
    logic        o_last;

    // Side channel travelling with each input beat: a typed-in expectation
    logic        tb_typed = 1'b0;
    t_fade_beat  tb_typed_exp = '0;

    // Predictor state, mirrors the block after reset
    logic [5:0]        fade_pos = '0;
    pfdc_pkg::t_offset fade_red = '0;
    pfdc_pkg::t_offset fade_green = '0;
    pfdc_pkg::t_offset fade_blue = '0;

    t_fade_beat  fade_expect_q[$];

    int          n_errors = 0;
    int          n_items_in = 0;
    int          n_results = 0;
    int          n_full_stalls = 0;
    int          n_passes = 0;
    int          n_holds = 0;
    bit          rx_hold_req = 1'b0;
    bit          tx_calm = 1'b0;

    // Directed table. Starts are 6-bit two's complement: 6'h20 is -32, 6'h3F is -1.
    t_stim_row stim_tab [0:STIM_ROWS-1] = '{
        // straight after reset, no pass started: zero offsets, position 0 then 1
        '{16'hFFFF, 1'b0, 6'h15, 6'h2A, 6'h3F, 1'b1, '{15'h7FFF, 6'd0, 1'b0}},
        '{16'h0000, 1'b0, 6'h1F, 6'h1F, 6'h1F, 1'b1, '{15'h0000, 6'd1, 1'b0}},
        // largest positive start saturates every channel, and holds in the low band
        '{16'h0000, 1'b1, 6'h1F, 6'h1F, 6'h1F, 1'b1, '{15'h7FFF, 6'd0, 1'b0}},
        '{16'h0000, 1'b0, 6'h00, 6'h00, 6'h00, 1'b1, '{15'h7FFF, 6'd1, 1'b0}},
        // most negative start floors a full-white entry
        '{16'h7FFF, 1'b1, 6'h20, 6'h20, 6'h20, 1'b1, '{15'h0000, 6'd0, 1'b0}},
        '{16'h7FFF, 1'b0, 6'h1F, 6'h00, 6'h1F, 1'b0, '0},
        // bit 15 of the colour plays no part
        '{16'h8000, 1'b1, 6'h00, 6'h00, 6'h00, 1'b1, '{15'h0000, 6'd0, 1'b0}},
        '{16'hD6B5, 1'b1, 6'h00, 6'h00, 6'h00, 1'b1, '{15'h56B5, 6'd0, 1'b0}},
        '{16'h7FFF, 1'b1, 6'h3F, 6'h3F, 6'h3F, 1'b1, '{15'h7BDE, 6'd0, 1'b0}},
        // mixed signs, then continuation beats whose start fields must be ignored
        '{16'h0421, 1'b1, 6'h05, 6'h39, 6'h00, 1'b0, '0},
        '{16'h7C1F, 1'b0, 6'h20, 6'h1F, 6'h20, 1'b0, '0},
        '{16'h03E0, 1'b0, 6'h1F, 6'h20, 6'h1F, 1'b0, '0},
        '{16'hFFFF, 1'b1, 6'h01, 6'h20, 6'h1F, 1'b0, '0},
        '{16'h8421, 1'b0, 6'h00, 6'h00, 6'h00, 1'b0, '0},
        '{16'h1234, 1'b1, 6'h20, 6'h01, 6'h3F, 1'b0, '0},
        '{16'h5A5A, 1'b0, 6'h2B, 6'h14, 6'h07, 1'b0, '0},
        '{16'hA5A5, 1'b0, 6'h11, 6'h22, 6'h33, 1'b0, '0},
        '{16'h001F, 1'b1, 6'h1E, 6'h21, 6'h10, 1'b0, '0},
        '{16'h7FE0, 1'b0, 6'h00, 6'h00, 6'h00, 1'b0, '0},
        '{16'h0000, 1'b1, 6'h3F, 6'h01, 6'h20, 1'b0, '0}
    };

    palette_fade_decay_clamp_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_color_in    (i_color_in),
        .i_first       (i_first),
        .i_red_start   (i_red_start),
        .i_green_start (i_green_start),
        .i_blue_start  (i_blue_start),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_color_out   (o_color_out),
        .o_position    (o_position),
        .o_last        (o_last)
    );

    initial begin
        forever begin
            #(CLK_HALF_NS) i_clk = ~i_clk;
        end
    end

    // Offset decay for one band: d - (d/p + d/q), int division truncates towards zero
    function automatic int shrink_offset(input int d, input logic [1:0] band);
        case (band)
            pfdc_pkg::BAND_4_5: return d - (d / 4 + d / 5);
            pfdc_pkg::BAND_4_3: return d - (d / 4 + d / 3);
            pfdc_pkg::BAND_2_3: return d - (d / 2 + d / 3);
            default:            return d;
        endcase
    endfunction

    function automatic logic [4:0] clamp5(input int v);
        if (v > 31) begin
            return 5'd31;
        end else if (v < 0) begin
            return 5'd0;
        end else begin
            return 5'(v);
        end
    endfunction

    // Advance the predictor by one accepted entry and return the beat it produces
    task automatic fade_advance(input logic [15:0] color, input logic first,
                                input pfdc_pkg::t_offset rs, input pfdc_pkg::t_offset gs,
                                input pfdc_pkg::t_offset bs,
                                output t_fade_beat res);
        logic [5:0] pos;
        int         r;
        int         g;
        int         b;
        if (first) begin
            pos = '0;
            r = int'(rs);
            g = int'(gs);
            b = int'(bs);
        end else begin
            pos = fade_pos;
            r = int'(fade_red);
            g = int'(fade_green);
            b = int'(fade_blue);
        end
        r = shrink_offset(r, pos[5:4]);
        g = shrink_offset(g, pos[5:4]);
        b = shrink_offset(b, pos[5:4]);
        fade_red   = pfdc_pkg::t_offset'(r);
        fade_green = pfdc_pkg::t_offset'(g);
        fade_blue  = pfdc_pkg::t_offset'(b);
        res.color = {clamp5(int'(color[14:10]) + b),
                     clamp5(int'(color[9:5]) + g),
                     clamp5(int'(color[4:0]) + r)};
        res.position = pos;
        res.last = (pos == 6'(pfdc_pkg::PASS_LENGTH - 1));
        fade_pos = pos + 6'd1;
    endtask

    // Idle length: mostly none, often short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end else if (roll < 95) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    // Colour biased towards the clamp edges of each channel
    function automatic logic [15:0] pick_color();
        logic [15:0] c;
        c = 16'($urandom);
        if ($urandom_range(0, 1) == 0) begin
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(0, 4))
                    0: c[k*5 +: 5] = 5'd0;
                    1: c[k*5 +: 5] = 5'd1;
                    2: c[k*5 +: 5] = 5'd30;
                    3: c[k*5 +: 5] = 5'd31;
                    default: ;
                endcase
            end
        end
        return c;
    endfunction

    // Start offset biased towards the signed extremes and around zero
    function automatic logic [5:0] pick_start();
        case ($urandom_range(0, 9))
            0: return 6'h20;
            1: return 6'h21;
            2: return 6'h1F;
            3: return 6'h1E;
            4: return 6'h3F;
            5: return 6'h01;
            default: return 6'($urandom);
        endcase
    endfunction

    // Offer one input beat after an optional idle gap; return once it is taken
    task automatic offer_beat(input logic [15:0] color, input logic first,
                              input logic [5:0] rs, input logic [5:0] gs,
                              input logic [5:0] bs, input logic typed,
                              input t_fade_beat exp);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push        <= 1'b1;
        i_color_in    <= color;
        i_first       <= first;
        i_red_start   <= rs;
        i_green_start <= gs;
        i_blue_start  <= bs;
        tb_typed      <= typed;
        tb_typed_exp  <= exp;
        // hold the beat until an edge sees push high and full low
        do begin
            @(posedge i_clk);
        end while (o_full !== 1'b0);
    endtask

    // Drop push and hold the sender until every expected result has been popped
    task automatic drain_results();
        i_push <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (fade_expect_q.size() != 0);
    endtask

    // Monitor: record accepted entries, then check accepted results, all on pre-edge values
    always @(posedge i_clk) begin
        t_fade_beat pred;
        t_fade_beat got;
        t_fade_beat want;
        if (i_rst_n) begin
            if (i_push && o_full) begin
                n_full_stalls++;
            end
            if (i_push && !o_full) begin
                fade_advance(i_color_in, i_first, i_red_start, i_green_start, i_blue_start,
                             pred);
                // a typed row still advances the predictor, but its own value is checked
                fade_expect_q.push_back(tb_typed ? tb_typed_exp : pred);
                n_items_in++;
            end
            if (i_pop && !o_empty) begin
                got = '{o_color_out, o_position, o_last};
                n_results++;
                if (fade_expect_q.size() == 0) begin
                    $display("%0t: result with nothing expected: colour %h pos %0d last %b",
                             $time, got.color, got.position, got.last);
                    n_errors++;
                end else begin
                    want = fade_expect_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch: expected colour %h pos %0d last %b,",
                                 $time, want.color, want.position, want.last,
                                 " got colour %h pos %0d last %b",
                                 got.color, got.position, got.last);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Receiver: pop with random gaps, calm stretches, and a long hold on request
    initial begin : rx_side
        int  stall_left;
        int  mode_left;
        int  gap;
        bit  calm;
        stall_left = 0;
        mode_left = 0;
        calm = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 200);
            end else begin
                mode_left--;
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left = RX_HOLD_CYCLES;
                n_holds++;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_pop <= 1'b0;
            end else begin
                gap = calm ? 0 : pick_gap();
                if (gap > 0) begin
                    stall_left = gap - 1;
                    i_pop <= 1'b0;
                end else begin
                    i_pop <= 1'b1;
                end
            end
        end
    end

    // Sender: reset, directed table, random passes, then drain and report
    initial begin : tx_side
        int       row;
        int       k;
        int       pass_len;
        int       items_sent;
        bit       carry_on;
        logic     first;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < STIM_ROWS; row++) begin
            offer_beat(stim_tab[row].color, stim_tab[row].first, stim_tab[row].red_st,
                       stim_tab[row].green_st, stim_tab[row].blue_st, stim_tab[row].typed,
                       stim_tab[row].exp);
        end
        drain_results();

        // Mostly well-formed passes; some run past the pass end and wrap, a few carry on
        // from the previous counter without a first beat.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            carry_on = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) < 3) begin
                pass_len = $urandom_range(60, 70);
            end else begin
                pass_len = $urandom_range(1, 64);
            end
            if (n_passes == 4 || n_passes == 20) begin
                // receiver holds off while the sender keeps offering back to back
                rx_hold_req = 1'b1;
                tx_calm = 1'b1;
                pass_len = 64;
            end
            if (n_passes == 12) begin
                drain_results();
            end
            for (k = 0; k < pass_len; k++) begin
                first = (k == 0) && !carry_on;
                offer_beat(pick_color(), first, pick_start(), pick_start(), pick_start(),
                           1'b0, '0);
                items_sent++;
            end
            n_passes++;
        end
        i_push <= 1'b0;

        while (fade_expect_q.size() != 0) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (fade_expect_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, fade_expect_q.size());
            n_errors++;
        end

        $display("Covered %0d entries in %0d random passes plus the directed table, %0d results",
                 n_items_in, n_passes, n_results);
        $display("Input stalled on full for %0d cycles across %0d long receiver holds",
                 n_full_stalls, n_holds);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("%0t: run timed out, %0d results still expected", $time, fade_expect_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### palette_fade_decay_clamp_unit.f
rtl/core/pfdc_pkg.sv
rtl/core/pfdc_front.sv
rtl/core/pfdc_queue.sv
rtl/core/pfdc_back.sv
rtl/core/palette_fade_decay_clamp_unit.sv
verif/tb_palette_fade_decay_clamp_unit.sv
